@@ sv/stt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the system tick timer
// Holds the counter geometry, the command and register address codes and
// the transaction structs passed between the top level and the timer core.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Counter geometry
  localparam int CountWidth   = 24;
  localparam int PrescaleDiv  = 8;
  localparam int PrescaleW    = (PrescaleDiv > 2) ? $clog2(PrescaleDiv) : 1;
  localparam int DataWidth    = 24;
  localparam int FlagBit      = 16;

  // Item kinds
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  // Register map
  typedef enum logic [1:0] {
    ADDR_CTRL    = 2'd0,
    ADDR_RELOAD  = 2'd1,
    ADDR_COUNT   = 2'd2,
    ADDR_ELAPSED = 2'd3
  } addr_e;

  // Control register bit positions
  localparam int CtrlRunBit    = 0;
  localparam int CtrlIrqBit    = 1;
  localparam int CtrlDirectBit = 2;
  localparam int CtrlOneShotBit = 3;

  // One input item
  typedef struct packed {
    cmd_e                  cmd;
    addr_e                 reg_addr;
    logic [DataWidth-1:0]  write_data;
  } item_t;

  // One result item
  typedef struct packed {
    logic [DataWidth-1:0]  read_data;
    logic                  irq_pulse;
  } result_t;

endpackage

@@ sv/stt_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_core: timer state and per-item update
// Holds the control bits, expiry flag, reload value, counter and prescaler,
// applies one item when fire_i is high and returns its result combinationally.
// ----------------------------------------------------------------------------
module stt_core
  import stt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic                  run_q, run_d;
  logic                  irq_en_q, irq_en_d;
  logic                  direct_q, direct_d;
  logic                  one_shot_q, one_shot_d;
  logic                  flag_q, flag_d;
  logic [CountWidth-1:0] reload_q, reload_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [PrescaleW-1:0]  presc_q, presc_d;

  logic                  presc_wrap;
  logic                  count_edge;
  logic [31:0]           rd_wide;
  logic [CountWidth-1:0] data_fit;
  logic [CountWidth-1:0] elapsed;

  assign presc_wrap = (presc_q >= PrescaleW'(PrescaleDiv - 1));
  assign count_edge = direct_q || presc_wrap;
  assign data_fit   = CountWidth'({8'd0, item_i.write_data});
  assign elapsed    = reload_q - count_q;

  // Apply one item to the timer state
  always_comb begin
    run_d      = run_q;
    irq_en_d   = irq_en_q;
    direct_d   = direct_q;
    one_shot_d = one_shot_q;
    flag_d     = flag_q;
    reload_d   = reload_q;
    count_d    = count_q;
    presc_d    = presc_q;
    rd_wide    = 32'd0;
    result_o.irq_pulse = 1'b0;

    if (fire_i) begin
      case (item_i.cmd)
        CMD_TICK: begin
          if (run_q) begin
            if (!direct_q) begin
              presc_d = presc_wrap ? '0 : presc_q + PrescaleW'(1);
            end
            if (count_edge) begin
              if (count_q == '0) begin
                count_d = reload_q;
              end else begin
                count_d = count_q - CountWidth'(1);
                if (count_q == CountWidth'(1)) begin
                  flag_d = 1'b1;
                  result_o.irq_pulse = irq_en_q;
                  if (one_shot_q) begin
                    run_d      = 1'b0;
                    reload_d   = '0;
                    one_shot_d = 1'b0;
                  end
                end
              end
            end
          end
        end
        CMD_READ: begin
          unique case (item_i.reg_addr)
            ADDR_CTRL: begin
              rd_wide[CtrlRunBit]     = run_q;
              rd_wide[CtrlIrqBit]     = irq_en_q;
              rd_wide[CtrlDirectBit]  = direct_q;
              rd_wide[CtrlOneShotBit] = one_shot_q;
              rd_wide[FlagBit]        = flag_q;
              flag_d = 1'b0;
            end
            ADDR_RELOAD:  rd_wide = 32'(reload_q);
            ADDR_COUNT:   rd_wide = 32'(count_q);
            ADDR_ELAPSED: rd_wide = 32'(elapsed);
            default:      rd_wide = 32'd0;
          endcase
        end
        CMD_WRITE: begin
          unique case (item_i.reg_addr)
            ADDR_CTRL: begin
              run_d      = item_i.write_data[CtrlRunBit];
              irq_en_d   = item_i.write_data[CtrlIrqBit];
              direct_d   = item_i.write_data[CtrlDirectBit];
              one_shot_d = item_i.write_data[CtrlOneShotBit];
            end
            ADDR_RELOAD: reload_d = data_fit;
            ADDR_COUNT: begin
              count_d = '0;
              flag_d  = 1'b0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    result_o.read_data = rd_wide[DataWidth-1:0];
  end

  // Hold timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      irq_en_q   <= 1'b0;
      direct_q   <= 1'b0;
      one_shot_q <= 1'b0;
      flag_q     <= 1'b0;
      reload_q   <= '0;
      count_q    <= '0;
      presc_q    <= '0;
    end else begin
      run_q      <= run_d;
      irq_en_q   <= irq_en_d;
      direct_q   <= direct_d;
      one_shot_q <= one_shot_d;
      flag_q     <= flag_d;
      reload_q   <= reload_d;
      count_q    <= count_d;
      presc_q    <= presc_d;
    end
  end

endmodule

@@ sv/system_tick_timer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// system_tick_timer: down-counting tick timer with a four-register bus view
// Usage:
//   The slave stream carries one transaction per item: a clock tick, a
//   register read or a register write, selected by tuser. The master stream
//   returns exactly one transaction per item with the read value (zero for
//   ticks and writes) and the interrupt pulse flag.
//   Path: an accepted item is held in the input register; the state update
//   then writes its result into the result register, from which it is
//   presented on the master stream.
//   Throughput: one item per cycle while m_axis_tready holds high; the state
//   update is a single compare, decrement and select between both registers.
//   Stall: when the master side holds tready low, the result register holds
//   and the input register still takes one more item; tready on the slave
//   side drops only when both registers are full.
//   Reset: clears all control bits, the flag, reload value, counter, prescaler
//   and the valid bits of both stream registers; no item is pending afterwards.
// ----------------------------------------------------------------------------
module system_tick_timer
  import stt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [1:0] reg_addr, [25:2] write_data, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [23:0] read_data, [24] irq_pulse, rest zero
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t core_res;
  logic    advance;
  logic    fire;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // Capture the incoming transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.cmd        <= cmd_e'(s_axis_tuser);
      in_item_q.reg_addr   <= addr_e'(s_axis_tdata[1:0]);
      in_item_q.write_data <= s_axis_tdata[DataWidth+1:2];
    end
  end

  stt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .result_o (core_res)
  );

  // Hold the result until the master side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_res_q.irq_pulse, out_res_q.read_data};

endmodule

@@ bench/timer_result_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_result_check: result checker for the system tick timer
// Follows every accepted input transaction through a private model of the
// timer state, queues the predicted result, and compares each returned
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module timer_result_check
  import stt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,   // [1:0] reg_addr, [25:2] write_data
  input  logic [1:0]  s_tuser_i,   // [1:0] cmd
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,   // [23:0] read_data, [24] irq_pulse
  output int          mismatches_o,
  output int          pending_o,
  output int          checked_o,
  output int          irqs_o
);

  // Predicted timer state
  logic                  run_en;
  logic                  irq_en;
  logic                  direct_clk;
  logic                  one_shot;
  logic                  expired;
  logic [CountWidth-1:0] reload;
  logic [CountWidth-1:0] count;
  int unsigned           prescale;

  result_t               predicted_results[$];
  result_t               want;
  logic [DataWidth-1:0]  got_data;
  logic                  got_irq;
  int                    errors;
  int                    compared;
  int                    pulses;

  // Apply one count edge; returns the interrupt pulse it causes
  function automatic logic step_counter();
    logic pulse;
    pulse = 1'b0;
    if (count == '0) begin
      count = reload;
    end else begin
      count = count - CountWidth'(1);
      if (count == '0) begin
        expired = 1'b1;
        pulse   = irq_en;
        // one-shot mode stops the timer whatever the interrupt setting
        if (one_shot) begin
          run_en   = 1'b0;
          reload   = '0;
          one_shot = 1'b0;
        end
      end
    end
    return pulse;
  endfunction

  // Advance the timer by one input item and return its result
  function automatic result_t predict_timer_item(input logic [1:0] cmd,
                                                 input logic [1:0] addr,
                                                 input logic [DataWidth-1:0] data);
    result_t r;
    r = '0;
    case (cmd)
      CMD_TICK: begin
        if (run_en) begin
          if (direct_clk) begin
            r.irq_pulse = step_counter();
          end else if (prescale >= PrescaleDiv - 1) begin
            prescale    = 0;
            r.irq_pulse = step_counter();
          end else begin
            prescale++;
          end
        end
      end
      CMD_READ: begin
        case (addr)
          ADDR_CTRL: begin
            r.read_data[CtrlRunBit]     = run_en;
            r.read_data[CtrlIrqBit]     = irq_en;
            r.read_data[CtrlDirectBit]  = direct_clk;
            r.read_data[CtrlOneShotBit] = one_shot;
            r.read_data[FlagBit]        = expired;
            expired = 1'b0;
          end
          ADDR_RELOAD: r.read_data = DataWidth'(reload);
          ADDR_COUNT:  r.read_data = DataWidth'(count);
          default:     r.read_data = DataWidth'(CountWidth'(reload - count));
        endcase
      end
      CMD_WRITE: begin
        case (addr)
          ADDR_CTRL: begin
            run_en     = data[CtrlRunBit];
            irq_en     = data[CtrlIrqBit];
            direct_clk = data[CtrlDirectBit];
            one_shot   = data[CtrlOneShotBit];
          end
          ADDR_RELOAD: reload = CountWidth'(data);
          ADDR_COUNT: begin
            count   = '0;
            expired = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_en     = 1'b0;
      irq_en     = 1'b0;
      direct_clk = 1'b0;
      one_shot   = 1'b0;
      expired    = 1'b0;
      reload     = '0;
      count      = '0;
      prescale   = 0;
      errors     = 0;
      compared   = 0;
      pulses     = 0;
      predicted_results.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        predicted_results.push_back(
          predict_timer_item(s_tuser_i, s_tdata_i[1:0], s_tdata_i[25:2]));
      end
      if (m_tvalid_i && m_tready_i) begin
        got_data = m_tdata_i[23:0];
        got_irq  = m_tdata_i[24];
        if (got_irq) pulses++;
        if (predicted_results.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result read_data %h irq_pulse %0b",
                     $time, got_data, got_irq);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          compared++;
          if (got_data !== want.read_data || got_irq !== want.irq_pulse) begin
            if (errors < 10)
              $display({"%0t: result %0d mismatch: read_data exp %h got %h, ",
                        "irq_pulse exp %0b got %0b"},
                       $time, compared, want.read_data, got_data, want.irq_pulse, got_irq);
            errors++;
          end
        end
      end
    end
    mismatches_o <= errors;
    pending_o    <= predicted_results.size();
    checked_o    <= compared;
    irqs_o       <= pulses;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stream testbench for the system tick timer
// Drives directed register and tick sequences, then random traffic under
// four pacing phases with a long output hold-off and a full drain, while
// the result checker predicts and compares every returned transaction.
// ----------------------------------------------------------------------------
module tb;
  import stt_pkg::*;

  localparam int         ClkPeriod  = 12;
  localparam int         CycleLimit = 200000;
  localparam int         HoldCycles = 150;
  localparam int         PhaseItems = 320;
  localparam logic [1:0] CmdUnused  = 2'd3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;

  int   mismatch_count;
  int   results_pending;
  int   results_checked;
  int   irq_pulses;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  logic hold_req   = 1'b0;
  int   hold_left  = 0;
  int   items_sent = 0;
  int   cycle_count = 0;
  int   idle_tab[4]  = '{0, 48, 0, 34};
  int   stall_tab[4] = '{0, 0, 48, 34};

  system_tick_timer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  timer_result_check u_result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .mismatches_o (mismatch_count),
    .pending_o    (results_pending),
    .checked_o    (results_checked),
    .irqs_o       (irq_pulses)
  );

  // Free-running clock
  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Stall the result side at random, or hold it off for a long stretch
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Offer one transaction, with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] cmd, input logic [1:0] addr,
                           input logic [DataWidth-1:0] data);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom() & 32'h03FF_FFFF;
      s_axis_tuser  <= 2'($urandom_range(3));
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, data, addr};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  // Random item, biased toward short reload periods and a running timer
  task automatic send_random();
    logic [1:0]           cmd;
    logic [1:0]           addr;
    logic [DataWidth-1:0] data;
    int                   pick;
    pick = $urandom_range(99);
    data = DataWidth'($urandom());
    addr = 2'($urandom_range(3));
    if (pick < 62) begin
      cmd = CMD_TICK;
    end else if (pick < 80) begin
      cmd = CMD_READ;
    end else if (pick < 97) begin
      cmd  = CMD_WRITE;
      pick = $urandom_range(9);
      if (pick < 4) begin
        addr = ADDR_RELOAD;
        if ($urandom_range(9) != 0) data = DataWidth'($urandom_range(12));
      end else if (pick < 7) begin
        addr = ADDR_CTRL;
        data[CtrlRunBit] = ($urandom_range(9) != 0);
      end else if (pick < 9) begin
        addr = ADDR_COUNT;
      end else begin
        addr = ADDR_ELAPSED;
      end
    end else begin
      cmd = CmdUnused;
    end
    send_item(cmd, addr, data);
  endtask

  // Stimulus and verdict
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset view, stopped timer, full-width reload and elapsed value
    send_item(CMD_READ,  ADDR_CTRL,    24'h000000);
    send_item(CMD_TICK,  ADDR_CTRL,    24'h000000);
    send_item(CMD_WRITE, ADDR_RELOAD,  24'hFFFFFF);
    send_item(CMD_READ,  ADDR_RELOAD,  24'h000000);
    send_item(CMD_READ,  ADDR_ELAPSED, 24'h000000);
    send_item(CMD_WRITE, ADDR_ELAPSED, 24'h123456);
    send_item(CmdUnused, ADDR_ELAPSED, 24'hFFFFFF);
    // run, irq, direct clock; upper data bits ignored
    send_item(CMD_WRITE, ADDR_CTRL,    24'hFFFFF7);
    send_item(CMD_TICK,  ADDR_CTRL,    24'h000000);
    send_item(CMD_TICK,  ADDR_CTRL,    24'h000000);
    send_item(CMD_READ,  ADDR_COUNT,   24'h000000);
    send_item(CMD_READ,  ADDR_ELAPSED, 24'h000000);
    // count write clears counter and flag
    send_item(CMD_WRITE, ADDR_COUNT,   24'hABCDEF);
    send_item(CMD_WRITE, ADDR_RELOAD,  24'h000002);
    repeat (3) send_item(CMD_TICK, ADDR_CTRL, 24'h000000);
    // flag shows once, then the read clears it
    send_item(CMD_READ,  ADDR_CTRL,    24'h000000);
    send_item(CMD_READ,  ADDR_CTRL,    24'h000000);
    // one-shot expiry without interrupt stops the timer
    send_item(CMD_WRITE, ADDR_CTRL,    24'h00000D);
    repeat (3) send_item(CMD_TICK, ADDR_CTRL, 24'h000000);
    send_item(CMD_READ,  ADDR_CTRL,    24'h000000);
    send_item(CMD_READ,  ADDR_RELOAD,  24'h000000);
    send_item(CMD_TICK,  ADDR_CTRL,    24'h000000);
    wait_drained();

    // random traffic under each pacing phase
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_tab[phase];
      stall_pct = stall_tab[phase];
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 0 && n == PhaseItems / 2) hold_req = 1'b1;
        send_random();
      end
      if (phase == 0) wait_drained();
    end

    idle_pct  = 0;
    stall_pct = 0;
    wait_drained();
    repeat (6) @(posedge clk_i);

    $display("Sent %0d items, checked %0d results with %0d interrupt pulses",
             items_sent, results_checked, irq_pulses);
    $display("Pacing: free run, input gaps, output stalls, both, plus a %0d-cycle hold-off",
             HoldCycles);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
